>>> src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bac_pkg.sv
package bac_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned OP_W   = 5;

    localparam logic [DATA_W-1:0] SIGN_MASK = 8'h80;
    localparam logic [DATA_W:0]   HALF_MASK = 9'h010;

    typedef logic [DATA_W-1:0] byte_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADC       = 5'd0,
        OP_ADD       = 5'd1,
        OP_AND       = 5'd2,
        OP_ASR       = 5'd3,
        OP_BIT       = 5'd4,
        OP_CLR       = 5'd5,
        OP_CMP       = 5'd6,
        OP_COM       = 5'd7,
        OP_DEC       = 5'd8,
        OP_EOR       = 5'd9,
        OP_INC       = 5'd10,
        OP_LD        = 5'd11,
        OP_LSL       = 5'd12,
        OP_LSR       = 5'd13,
        OP_NEG       = 5'd14,
        OP_OR        = 5'd15,
        OP_ROL       = 5'd16,
        OP_ROR       = 5'd17,
        OP_SBC       = 5'd18,
        OP_SUB       = 5'd19,
        OP_TST       = 5'd20,
        OP_FLAGWRITE = 5'd21
    } op_t;

    typedef struct packed {
        logic half;
        logic negative;
        logic zero;
        logic carry;
    } flags_t;

    localparam flags_t FLAGS_RESET = '0;

endpackage

>>> src/bac_alu.sv
module bac_alu (
    input  logic [bac_pkg::OP_W-1:0] op,
    input  bac_pkg::byte_t           operand_a,
    input  bac_pkg::byte_t           operand_b,
    input  bac_pkg::flags_t          flags_in,
    output bac_pkg::byte_t           result,
    output bac_pkg::flags_t          flags_out
);

    logic [bac_pkg::DATA_W:0] sum_w;
    logic [bac_pkg::DATA_W:0] diff_w;
    logic [bac_pkg::DATA_W:0] low_sum_w;
    logic                     cin;
    bac_pkg::byte_t           zn_src;
    logic                     set_zn;

    // shared adder and subtractor, carry in only for adc and sbc
    always_comb begin
        cin       = ((op == bac_pkg::OP_ADC) || (op == bac_pkg::OP_SBC)) ? flags_in.carry : 1'b0;
        sum_w     = {1'b0, operand_a} + {1'b0, operand_b} + {{bac_pkg::DATA_W{1'b0}}, cin};
        diff_w    = {1'b0, operand_a} - {1'b0, operand_b} - {{bac_pkg::DATA_W{1'b0}}, cin};
        low_sum_w = {5'd0, operand_a[3:0]} + {5'd0, operand_b[3:0]}
                  + {{bac_pkg::DATA_W{1'b0}}, cin};
    end

    always_comb begin
        result    = operand_a;
        flags_out = flags_in;
        zn_src    = operand_a;
        set_zn    = 1'b1;
        case (op)
            bac_pkg::OP_ADC, bac_pkg::OP_ADD: begin
                result          = sum_w[bac_pkg::DATA_W-1:0];
                flags_out.carry = sum_w[bac_pkg::DATA_W];
                flags_out.half  = |(low_sum_w & bac_pkg::HALF_MASK);
                zn_src          = result;
            end
            bac_pkg::OP_SBC, bac_pkg::OP_SUB: begin
                result          = diff_w[bac_pkg::DATA_W-1:0];
                flags_out.carry = diff_w[bac_pkg::DATA_W];
                zn_src          = result;
            end
            bac_pkg::OP_CMP: begin
                flags_out.carry = diff_w[bac_pkg::DATA_W];
                zn_src          = diff_w[bac_pkg::DATA_W-1:0];
            end
            bac_pkg::OP_AND: begin
                result = operand_a & operand_b;
                zn_src = result;
            end
            bac_pkg::OP_BIT: begin
                zn_src = operand_a & operand_b;
            end
            bac_pkg::OP_EOR: begin
                result = operand_a ^ operand_b;
                zn_src = result;
            end
            bac_pkg::OP_OR: begin
                result = operand_a | operand_b;
                zn_src = result;
            end
            bac_pkg::OP_LD: begin
                result = operand_b;
                zn_src = result;
            end
            bac_pkg::OP_CLR: begin
                result = '0;
                zn_src = '0;
            end
            bac_pkg::OP_COM: begin
                result          = ~operand_a;
                flags_out.carry = 1'b1;
                zn_src          = result;
            end
            bac_pkg::OP_NEG: begin
                result          = '0 - operand_a;
                flags_out.carry = |result;
                zn_src          = result;
            end
            bac_pkg::OP_INC: begin
                result = operand_a + 8'd1;
                zn_src = result;
            end
            bac_pkg::OP_DEC: begin
                result = operand_a - 8'd1;
                zn_src = result;
            end
            bac_pkg::OP_ASR: begin
                result          = (operand_a >> 1) | (operand_a & bac_pkg::SIGN_MASK);
                flags_out.carry = operand_a[0];
                zn_src          = result;
            end
            bac_pkg::OP_LSR: begin
                result          = operand_a >> 1;
                flags_out.carry = operand_a[0];
                zn_src          = result;
            end
            bac_pkg::OP_ROR: begin
                result          = {flags_in.carry, operand_a[bac_pkg::DATA_W-1:1]};
                flags_out.carry = operand_a[0];
                zn_src          = result;
            end
            bac_pkg::OP_LSL: begin
                result          = operand_a << 1;
                flags_out.carry = operand_a[bac_pkg::DATA_W-1];
                zn_src          = result;
            end
            bac_pkg::OP_ROL: begin
                result          = {operand_a[bac_pkg::DATA_W-2:0], flags_in.carry};
                flags_out.carry = operand_a[bac_pkg::DATA_W-1];
                zn_src          = result;
            end
            bac_pkg::OP_TST: begin
                zn_src = operand_a;
            end
            bac_pkg::OP_FLAGWRITE: begin
                flags_out = bac_pkg::flags_t'(operand_b[3:0]);
                set_zn    = 1'b0;
            end
            default: begin
                set_zn = 1'b0;
            end
        endcase
        if (set_zn) begin
            flags_out.zero     = (zn_src == '0);
            flags_out.negative = |(zn_src & bac_pkg::SIGN_MASK);
        end
    end

endmodule

>>> src/byte_alu_with_condition_flags.sv
// Eight-bit ALU with carry, zero, negative and half carry flags. An item is an
// operation code and two operand bytes; each item gives one result item holding
// the result byte and the four flags as they stand after the operation. The
// flags start cleared after reset and carry from one item to the next. An item
// is registered on accept into the input register, passes through the ALU, and
// its result and flags are registered at the output once the output is free.
// One item is taken every clock while results are taken. The flag register
// sits on the ALU output and feeds back into the ALU as the flags of the next
// item, which allows the one item per clock rate.
`include "assert_macros.svh"

module byte_alu_with_condition_flags (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [bac_pkg::OP_W-1:0] s_req_type,
    input  bac_pkg::byte_t           s_operand_a,
    input  bac_pkg::byte_t           s_operand_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bac_pkg::byte_t           m_result,
    output logic                     m_carry_out,
    output logic                     m_zero_out,
    output logic                     m_negative_out,
    output logic                     m_half_out
);

    logic                     in_valid_reg;
    logic [bac_pkg::OP_W-1:0] in_op_reg;
    bac_pkg::byte_t           in_a_reg;
    bac_pkg::byte_t           in_b_reg;
    logic                     m_valid_reg;
    bac_pkg::byte_t           result_reg;
    bac_pkg::byte_t           result_next;
    bac_pkg::flags_t          flags_reg;
    bac_pkg::flags_t          flags_next;
    logic                     out_free;
    logic                     advance;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg <= s_req_type;
            in_a_reg  <= s_operand_a;
            in_b_reg  <= s_operand_b;
        end
    end

    bac_alu u_alu (
        .op        (in_op_reg),
        .operand_a (in_a_reg),
        .operand_b (in_b_reg),
        .flags_in  (flags_reg),
        .result    (result_next),
        .flags_out (flags_next)
    );

    // flags double as the result item's flag fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            flags_reg   <= bac_pkg::FLAGS_RESET;
        end else begin
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            if (advance) begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result       = result_reg;
    assign m_carry_out    = flags_reg.carry;
    assign m_zero_out     = flags_reg.zero;
    assign m_negative_out = flags_reg.negative;
    assign m_half_out     = flags_reg.half;

    `ASSERT_ALWAYS(a_reset_clears, aclk,
        !aresetn |=> (flags_reg == bac_pkg::FLAGS_RESET && !m_valid_reg && !in_valid_reg),
        "reset did not clear flags and valids")
    `ASSERT_CLK(a_flags_hold, aclk, aresetn, !advance |=> $stable(flags_reg),
        "flags changed without an item")
    `ASSERT_CLK(a_item_moves, aclk, aresetn, advance |=> m_valid_reg,
        "item lost between stages")
    `ASSERT_CLK(a_stall_holds, aclk, aresetn,
        (m_valid_reg && !m_ready) |=> ($stable(result_reg) && $stable(flags_reg)),
        "stalled result changed")

endmodule
